// ----- hdl/buddy_page_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// buddy page allocator assertion macros
// property wrappers that fall away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define BPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants, codes and types of the buddy page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int NUM_PAGES = 32768;
    localparam int MAX_ORDER = 14;
    localparam int NUM_ORD   = MAX_ORDER + 1;
    localparam int PW        = 15;   // page index
    localparam int LW        = 16;   // link, holds null
    localparam int OW        = 4;    // order
    localparam int CW        = 16;   // free page count
    localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);

    // byte address of the first_page register
    localparam logic [2:0] REG_FIRST_PAGE = 3'd0;

    typedef enum logic [1:0] {
        PS_UNUSED = 2'd0,
        PS_FREE   = 2'd1,
        PS_ALLOC  = 2'd2
    } t_pstate;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_BLOCK  = 3'd1,
        ST_BAD_ORDER = 3'd2,
        ST_RANGE     = 3'd3,
        ST_MISALIGN  = 3'd4,
        ST_NOT_ALLOC = 3'd5,
        ST_MISMATCH  = 3'd6
    } t_status;

    typedef enum logic [4:0] {
        S_RCLR, S_IDLE, S_ISTART, S_ICLR, S_CARVE, S_PUSH, S_PLINK,
        S_ACHK, S_ARD, S_U1, S_U2, S_SPLIT, S_FCHK, S_FCHK2,
        S_MRD, S_MCHK, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLR_START, OP_CLR_STEP, OP_CARVE_SEL, OP_PUSH,
        OP_PUSH_LINK, OP_ALLOC_SEL, OP_READ_PG, OP_UNLINK1, OP_UNLINK2,
        OP_SPLIT, OP_ALLOC_FIN, OP_STATUS, OP_READ_IDX, OP_FREE_CLR,
        OP_MERGE_RD, OP_MERGE_PUSH
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic clr_last;
        logic carve_end;
        logic link_needed;
        logic req_bad;
        logic none_found;
        logic range_bad;
        logic misaligned;
        logic not_alloc;
        logic ord_mis;
        logic merge_stop;
        logic merge_ok;
        logic split_more;
    } t_dp_sts;

    // largest aligned block that fits from this page
    function automatic logic [OW-1:0] carve_order(input logic [LW-1:0] idx);
        logic [OW-1:0] r;
        logic [LW:0]   n;
        r = '0;
        for (int k = 1; k <= MAX_ORDER; k++) begin
            n = (LW+1)'(1) << k;
            if (((LW+1)'(idx) & (n - (LW+1)'(1))) == '0 &&
                (LW+1)'(idx) + n <= (LW+1)'(NUM_PAGES)) begin
                r = OW'(k);
            end
        end
        return r;
    endfunction

endpackage

// ----- hdl/bpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpa_ctrl
// sequencer that steps the datapath through clear, carve, alloc and free
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_cmd,
    input  bpa_pkg::t_dp_sts i_sts,
    output bpa_pkg::t_dp_cmd o_dp,
    output logic             busy,
    output logic             o_done
);

    bpa_pkg::t_state r_state, n_state;

    // state register, reset enters the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_RCLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath command
    always_comb begin
        n_state      = r_state;
        o_dp.op      = bpa_pkg::OP_NONE;
        o_dp.code    = bpa_pkg::ST_OK;
        case (r_state)
            bpa_pkg::S_RCLR: begin
                o_dp.op = bpa_pkg::OP_CLR_STEP;
                if (i_sts.clr_last) n_state = bpa_pkg::S_IDLE;
            end
            bpa_pkg::S_IDLE: begin
                if (start) begin
                    o_dp.op = bpa_pkg::OP_LOAD;
                    case (bpa_pkg::t_cmd'(i_cmd))
                        bpa_pkg::CMD_INIT:  n_state = bpa_pkg::S_ISTART;
                        bpa_pkg::CMD_ALLOC: n_state = bpa_pkg::S_ACHK;
                        bpa_pkg::CMD_FREE:  n_state = bpa_pkg::S_FCHK;
                        default:            n_state = bpa_pkg::S_DONE;
                    endcase
                end
            end
            bpa_pkg::S_ISTART: begin
                o_dp.op = bpa_pkg::OP_CLR_START;
                n_state = bpa_pkg::S_ICLR;
            end
            bpa_pkg::S_ICLR: begin
                o_dp.op = bpa_pkg::OP_CLR_STEP;
                if (i_sts.clr_last) n_state = bpa_pkg::S_CARVE;
            end
            bpa_pkg::S_CARVE: begin
                if (i_sts.carve_end) begin
                    n_state = bpa_pkg::S_DONE;
                end else begin
                    o_dp.op = bpa_pkg::OP_CARVE_SEL;
                    n_state = bpa_pkg::S_PUSH;
                end
            end
            bpa_pkg::S_PUSH: begin
                o_dp.op = bpa_pkg::OP_PUSH;
                n_state = bpa_pkg::S_PLINK;
            end
            bpa_pkg::S_PLINK: begin
                if (i_sts.link_needed) o_dp.op = bpa_pkg::OP_PUSH_LINK;
                case (i_sts.cmd)
                    bpa_pkg::CMD_INIT:  n_state = bpa_pkg::S_CARVE;
                    bpa_pkg::CMD_ALLOC: n_state = bpa_pkg::S_SPLIT;
                    default:            n_state = bpa_pkg::S_DONE;
                endcase
            end
            // allocate: check the order, then pick the lowest non-empty list at or above it
            bpa_pkg::S_ACHK: begin
                if (i_sts.req_bad) begin
                    o_dp.op   = bpa_pkg::OP_STATUS;
                    o_dp.code = bpa_pkg::ST_BAD_ORDER;
                    n_state   = bpa_pkg::S_DONE;
                end else if (i_sts.none_found) begin
                    o_dp.op   = bpa_pkg::OP_STATUS;
                    o_dp.code = bpa_pkg::ST_NO_BLOCK;
                    n_state   = bpa_pkg::S_DONE;
                end else begin
                    o_dp.op = bpa_pkg::OP_ALLOC_SEL;
                    n_state = bpa_pkg::S_ARD;
                end
            end
            bpa_pkg::S_ARD: begin
                o_dp.op = bpa_pkg::OP_READ_PG;
                n_state = bpa_pkg::S_U1;
            end
            bpa_pkg::S_U1: begin
                o_dp.op = bpa_pkg::OP_UNLINK1;
                n_state = bpa_pkg::S_U2;
            end
            bpa_pkg::S_U2: begin
                o_dp.op = bpa_pkg::OP_UNLINK2;
                if (i_sts.cmd == bpa_pkg::CMD_ALLOC) n_state = bpa_pkg::S_SPLIT;
                else                                 n_state = bpa_pkg::S_MRD;
            end
            bpa_pkg::S_SPLIT: begin
                if (i_sts.split_more) begin
                    o_dp.op = bpa_pkg::OP_SPLIT;
                    n_state = bpa_pkg::S_PUSH;
                end else begin
                    o_dp.op = bpa_pkg::OP_ALLOC_FIN;
                    n_state = bpa_pkg::S_DONE;
                end
            end
            // free: static checks, then record checks
            bpa_pkg::S_FCHK: begin
                if (i_sts.req_bad) begin
                    o_dp.op   = bpa_pkg::OP_STATUS;
                    o_dp.code = bpa_pkg::ST_BAD_ORDER;
                    n_state   = bpa_pkg::S_DONE;
                end else if (i_sts.range_bad) begin
                    o_dp.op   = bpa_pkg::OP_STATUS;
                    o_dp.code = bpa_pkg::ST_RANGE;
                    n_state   = bpa_pkg::S_DONE;
                end else if (i_sts.misaligned) begin
                    o_dp.op   = bpa_pkg::OP_STATUS;
                    o_dp.code = bpa_pkg::ST_MISALIGN;
                    n_state   = bpa_pkg::S_DONE;
                end else begin
                    o_dp.op = bpa_pkg::OP_READ_IDX;
                    n_state = bpa_pkg::S_FCHK2;
                end
            end
            bpa_pkg::S_FCHK2: begin
                if (i_sts.not_alloc) begin
                    o_dp.op   = bpa_pkg::OP_STATUS;
                    o_dp.code = bpa_pkg::ST_NOT_ALLOC;
                    n_state   = bpa_pkg::S_DONE;
                end else if (i_sts.ord_mis) begin
                    o_dp.op   = bpa_pkg::OP_STATUS;
                    o_dp.code = bpa_pkg::ST_MISMATCH;
                    n_state   = bpa_pkg::S_DONE;
                end else begin
                    o_dp.op = bpa_pkg::OP_FREE_CLR;
                    n_state = bpa_pkg::S_MRD;
                end
            end
            // merge loop, one buddy per pass
            bpa_pkg::S_MRD: begin
                if (i_sts.merge_stop) begin
                    o_dp.op = bpa_pkg::OP_MERGE_PUSH;
                    n_state = bpa_pkg::S_PUSH;
                end else begin
                    o_dp.op = bpa_pkg::OP_MERGE_RD;
                    n_state = bpa_pkg::S_MCHK;
                end
            end
            bpa_pkg::S_MCHK: begin
                if (i_sts.merge_ok) begin
                    n_state = bpa_pkg::S_U1;
                end else begin
                    o_dp.op = bpa_pkg::OP_MERGE_PUSH;
                    n_state = bpa_pkg::S_PUSH;
                end
            end
            bpa_pkg::S_DONE: begin
                n_state = bpa_pkg::S_IDLE;
            end
            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != bpa_pkg::S_IDLE);
    assign o_done = (r_state == bpa_pkg::S_DONE);

endmodule

// ----- hdl/bpa_datapath.sv -----
// ----------------------------------------------------------------------------
// bpa_datapath
// page record memories, free list heads and working registers
// ----------------------------------------------------------------------------
module bpa_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bpa_pkg::t_dp_cmd            i_dp,
    input  logic [1:0]                  i_cmd,
    input  logic [bpa_pkg::OW-1:0]      i_order,
    input  logic [bpa_pkg::PW-1:0]      i_block_index,
    input  logic [bpa_pkg::PW-1:0]      i_first_page,
    output bpa_pkg::t_dp_sts            o_sts,
    output logic [2:0]                  o_status,
    output logic [bpa_pkg::PW-1:0]      o_granted_index,
    output logic [bpa_pkg::CW-1:0]      o_free_total
);

    localparam int PW = bpa_pkg::PW;
    localparam int LW = bpa_pkg::LW;
    localparam int OW = bpa_pkg::OW;
    localparam int CW = bpa_pkg::CW;
    localparam logic [LW:0] END_PG = (LW+1)'(bpa_pkg::NUM_PAGES);

    // page record memories
    logic [LW-1:0] m_next  [bpa_pkg::NUM_PAGES];
    logic [LW-1:0] m_prev  [bpa_pkg::NUM_PAGES];
    logic [OW-1:0] m_ord   [bpa_pkg::NUM_PAGES];
    logic [1:0]    m_state [bpa_pkg::NUM_PAGES];
    logic [LW-1:0] q_next, q_prev;
    logic [OW-1:0] q_ord;
    logic [1:0]    q_state;

    // list heads and working registers
    logic [LW-1:0]    r_head [bpa_pkg::NUM_ORD];
    bpa_pkg::t_cmd    r_cmd;
    logic [OW-1:0]    r_req, r_o, r_pord, r_uo;
    logic [LW-1:0]    r_idx, r_h;
    logic [PW-1:0]    r_pg, r_ppg, r_ut, r_clr, r_granted;
    logic [CW-1:0]    r_free;
    bpa_pkg::t_status r_status;

    // memory port controls
    logic          we_n, we_p, we_o, we_s, rd_en;
    logic [PW-1:0] wa_n, wa_p, wa_o, wa_s, rd_addr;
    logic [LW-1:0] wd_n, wd_p;
    logic [OW-1:0] wd_o;
    logic [1:0]    wd_s;

    // derived values
    logic [OW-1:0] h_sel, found, c_ord, o_dec;
    logic [LW-1:0] head_q;
    logic          any;
    logic [LW:0]   n_req, n_o, idx_x, bud_x;
    logic [PW-1:0] bud;

    assign h_sel  = (i_dp.op == bpa_pkg::OP_PUSH) ? r_pord : r_uo;
    assign head_q = r_head[h_sel];
    assign c_ord  = bpa_pkg::carve_order(r_idx);
    assign o_dec  = r_o - OW'(1);
    assign n_req  = (LW+1)'(1) << r_req;
    assign n_o    = (LW+1)'(1) << r_o;
    assign idx_x  = (LW+1)'(r_idx);
    assign bud    = r_idx[PW-1:0] ^ n_o[PW-1:0];
    assign bud_x  = (LW+1)'(bud);

    // lowest non-empty order at or above the request
    always_comb begin
        found = '0;
        any   = 1'b0;
        for (int k = bpa_pkg::MAX_ORDER; k >= 0; k--) begin
            if (OW'(k) >= r_req && r_head[k] != bpa_pkg::NIL) begin
                found = OW'(k);
                any   = 1'b1;
            end
        end
    end

    // status towards the sequencer
    always_comb begin
        o_sts.cmd         = r_cmd;
        o_sts.clr_last    = (r_clr == '1);
        o_sts.carve_end   = (idx_x >= END_PG);
        o_sts.link_needed = (r_h != bpa_pkg::NIL);
        o_sts.req_bad     = (r_req > OW'(bpa_pkg::MAX_ORDER));
        o_sts.none_found  = !any;
        o_sts.range_bad   = (idx_x < (LW+1)'(i_first_page)) || (idx_x + n_req > END_PG);
        o_sts.misaligned  = ((idx_x & (n_req - (LW+1)'(1))) != '0);
        o_sts.not_alloc   = (q_state != bpa_pkg::PS_ALLOC);
        o_sts.ord_mis     = (q_ord != r_req);
        o_sts.merge_stop  = (r_o >= OW'(bpa_pkg::MAX_ORDER)) ||
                            (bud_x < (LW+1)'(i_first_page)) || (bud_x + n_o > END_PG);
        o_sts.merge_ok    = (q_state == bpa_pkg::PS_FREE) && (q_ord == r_o);
        o_sts.split_more  = (r_o > r_req);
    end

    // memory write and read selection
    always_comb begin
        we_n = 1'b0; wa_n = r_ppg; wd_n = bpa_pkg::NIL;
        we_p = 1'b0; wa_p = r_ppg; wd_p = bpa_pkg::NIL;
        we_o = 1'b0; wa_o = r_ppg; wd_o = '0;
        we_s = 1'b0; wa_s = r_ppg; wd_s = bpa_pkg::PS_UNUSED;
        rd_en = 1'b0; rd_addr = r_idx[PW-1:0];
        case (i_dp.op)
            bpa_pkg::OP_CLR_STEP: begin
                {we_n, we_p, we_o, we_s} = 4'b1111;
                wa_n = r_clr; wa_p = r_clr; wa_o = r_clr; wa_s = r_clr;
            end
            bpa_pkg::OP_PUSH: begin
                {we_n, we_p, we_o, we_s} = 4'b1111;
                wd_n = head_q; wd_o = r_pord; wd_s = bpa_pkg::PS_FREE;
            end
            bpa_pkg::OP_PUSH_LINK: begin
                we_p = 1'b1; wa_p = r_h[PW-1:0]; wd_p = LW'(r_ppg);
            end
            bpa_pkg::OP_UNLINK1: begin
                we_n = (q_prev != bpa_pkg::NIL); wa_n = q_prev[PW-1:0]; wd_n = q_next;
                we_p = (q_next != bpa_pkg::NIL); wa_p = q_next[PW-1:0]; wd_p = q_prev;
            end
            bpa_pkg::OP_UNLINK2: begin
                {we_n, we_p, we_o, we_s} = 4'b1111;
                wa_n = r_ut; wa_p = r_ut; wa_o = r_ut; wa_s = r_ut;
            end
            bpa_pkg::OP_ALLOC_FIN: begin
                {we_n, we_p, we_o, we_s} = 4'b1111;
                wa_n = r_pg; wa_p = r_pg; wa_o = r_pg; wa_s = r_pg;
                wd_o = r_req; wd_s = bpa_pkg::PS_ALLOC;
            end
            bpa_pkg::OP_FREE_CLR: begin
                {we_n, we_p, we_o, we_s} = 4'b1111;
                wa_n = r_idx[PW-1:0]; wa_p = r_idx[PW-1:0];
                wa_o = r_idx[PW-1:0]; wa_s = r_idx[PW-1:0];
            end
            bpa_pkg::OP_READ_PG: begin
                rd_en = 1'b1; rd_addr = head_q[PW-1:0];
            end
            bpa_pkg::OP_READ_IDX: begin
                rd_en = 1'b1;
            end
            bpa_pkg::OP_MERGE_RD: begin
                rd_en = 1'b1; rd_addr = bud;
            end
            default: begin
            end
        endcase
    end

    // record memories, registered read
    always_ff @(posedge i_clk) begin
        if (we_n) m_next[wa_n] <= wd_n;
        if (we_p) m_prev[wa_p] <= wd_p;
        if (we_o) m_ord[wa_o] <= wd_o;
        if (we_s) m_state[wa_s] <= wd_s;
        if (rd_en) begin
            q_next  <= m_next[rd_addr];
            q_prev  <= m_prev[rd_addr];
            q_ord   <= m_ord[rd_addr];
            q_state <= m_state[rd_addr];
        end
    end

    // heads, free count and clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bpa_pkg::NUM_ORD; k++) r_head[k] <= bpa_pkg::NIL;
            r_free <= '0;
            r_clr  <= '0;
        end else begin
            case (i_dp.op)
                bpa_pkg::OP_CLR_START: begin
                    for (int k = 0; k < bpa_pkg::NUM_ORD; k++) r_head[k] <= bpa_pkg::NIL;
                    r_free <= '0;
                    r_clr  <= '0;
                end
                bpa_pkg::OP_CLR_STEP:  r_clr <= r_clr + PW'(1);
                bpa_pkg::OP_CARVE_SEL: r_free <= r_free + (CW'(1) << c_ord);
                bpa_pkg::OP_PUSH:      r_head[r_pord] <= LW'(r_ppg);
                bpa_pkg::OP_UNLINK1: begin
                    if (q_prev == bpa_pkg::NIL) r_head[r_uo] <= q_next;
                end
                bpa_pkg::OP_ALLOC_FIN:  r_free <= r_free - CW'(n_req);
                bpa_pkg::OP_MERGE_PUSH: r_free <= r_free + CW'(n_req);
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_dp.op)
            bpa_pkg::OP_LOAD: begin
                r_cmd     <= bpa_pkg::t_cmd'(i_cmd);
                r_req     <= i_order;
                r_idx     <= LW'(i_block_index);
                r_status  <= bpa_pkg::ST_OK;
                r_granted <= '0;
            end
            bpa_pkg::OP_CLR_START: r_idx <= LW'(i_first_page);
            bpa_pkg::OP_CARVE_SEL: begin
                r_ppg  <= r_idx[PW-1:0];
                r_pord <= c_ord;
                r_idx  <= r_idx + (LW'(1) << c_ord);
            end
            bpa_pkg::OP_PUSH: r_h <= head_q;
            bpa_pkg::OP_ALLOC_SEL: begin
                r_uo <= found;
                r_o  <= found;
            end
            bpa_pkg::OP_READ_PG: begin
                r_pg <= head_q[PW-1:0];
                r_ut <= head_q[PW-1:0];
            end
            bpa_pkg::OP_UNLINK2: begin
                if (r_cmd == bpa_pkg::CMD_FREE) begin
                    if (LW'(r_ut) < r_idx) r_idx <= LW'(r_ut);
                    r_o <= r_o + OW'(1);
                end
            end
            bpa_pkg::OP_SPLIT: begin
                r_o    <= o_dec;
                r_pord <= o_dec;
                r_ppg  <= r_pg + (PW'(1) << o_dec);
            end
            bpa_pkg::OP_ALLOC_FIN: r_granted <= r_pg;
            bpa_pkg::OP_STATUS:    r_status  <= i_dp.code;
            bpa_pkg::OP_FREE_CLR:  r_o       <= r_req;
            bpa_pkg::OP_MERGE_RD: begin
                r_ut <= bud;
                r_uo <= r_o;
            end
            bpa_pkg::OP_MERGE_PUSH: begin
                r_ppg  <= r_idx[PW-1:0];
                r_pord <= r_o;
            end
            default: begin
            end
        endcase
    end

    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_free_total    = r_free;

endmodule

// ----- hdl/buddy_page_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_page_allocator
// binary buddy allocator over a page array with per-order free lists
// ----------------------------------------------------------------------------
// reset: first_page to 0, then a sweep that clears the record memories, busy high
// init: clears the record memories, then carves blocks from first_page onto the lists
// alloc: takes the lowest non-empty list at or above the order, then splits it down
// free: checks the block, then merges it with free buddies of equal order and pushes it
// errors end a command at the failing check, an unknown command goes straight to done
// one transaction at a time, next accepted the cycle after o_done; no stall
module buddy_page_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_order,
    input  logic [14:0] i_block_index,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [14:0] o_granted_index,
    output logic [15:0] o_free_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [bpa_pkg::PW-1:0] r_first_page;
    bpa_pkg::t_dp_cmd       dp_cmd;
    bpa_pkg::t_dp_sts       dp_sts;
    logic                   bad_result;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page <= '0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_first_page <= pwdata[bpa_pkg::PW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_first_page);

    // sequencer
    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_sts   (dp_sts),
        .o_dp    (dp_cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // datapath
    bpa_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp            (dp_cmd),
        .i_cmd           (i_cmd),
        .i_order         (i_order),
        .i_block_index   (i_block_index),
        .i_first_page    (r_first_page),
        .o_sts           (dp_sts),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_free_total    (o_free_total)
    );

    assign bad_result = o_done && (o_status != bpa_pkg::ST_OK);

    // checks
    `include "buddy_page_allocator_assert.svh"
    `BPA_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `BPA_ASSERT_NOW(a_err_no_grant, i_clk, i_rst_n, bad_result, o_granted_index == 15'd0)
    `BPA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `BPA_ASSERT_NOW(a_free_bound, i_clk, i_rst_n, o_done, o_free_total <= 16'd32768)

endmodule

// ----- verif/buddy_page_allocator_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy page allocator checker
// tracks the free lists and page records alongside the block, works out the
// answer to every accepted command and compares each strobed result with it
// ----------------------------------------------------------------------------
module buddy_page_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_order,
    input  logic [14:0] i_block_index,
    input  logic        i_done,
    input  logic [2:0]  i_status,
    input  logic [14:0] i_granted_index,
    input  logic [15:0] i_free_total,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors
);

    localparam int NULL_PAGE = bpa_pkg::NUM_PAGES;
    localparam int NPG       = bpa_pkg::NUM_PAGES;
    localparam int NORD      = bpa_pkg::NUM_ORD;
    localparam int MAXO      = bpa_pkg::MAX_ORDER;

    typedef struct {
        bpa_pkg::t_status status;
        logic [14:0]      granted;
        logic [15:0]      total;
    } t_answer;

    t_answer     answer_q[$];
    int          mismatches;

    // shadow allocator state
    int               first_page;
    int               list_head[NORD];
    int               list_cnt[NORD];
    int               pg_next[NPG];
    int               pg_prev[NPG];
    logic [3:0]       pg_order[NPG];
    bpa_pkg::t_pstate pg_state[NPG];
    int               shadow_free;

    function automatic void wipe_records();
        for (int i = 0; i < NORD; i++) begin
            list_head[i] = NULL_PAGE;
            list_cnt[i]  = 0;
        end
        for (int i = 0; i < NPG; i++) begin
            pg_next[i]  = NULL_PAGE;
            pg_prev[i]  = NULL_PAGE;
            pg_order[i] = '0;
            pg_state[i] = bpa_pkg::PS_UNUSED;
        end
        shadow_free = 0;
    endfunction

    // head insertion onto a free list
    function automatic void link_head(int pg, int lv);
        int h;
        h = list_head[lv];
        pg_state[pg] = bpa_pkg::PS_FREE;
        pg_order[pg] = 4'(lv);
        pg_prev[pg]  = NULL_PAGE;
        pg_next[pg]  = h;
        if (h < NULL_PAGE) pg_prev[h] = pg;
        list_head[lv] = pg;
        list_cnt[lv]++;
    endfunction

    function automatic void unlink_free(int pg, int lv);
        int nx, pv;
        nx = pg_next[pg];
        pv = pg_prev[pg];
        if (pv < NULL_PAGE) pg_next[pv] = nx;
        else list_head[lv] = nx;
        if (nx < NULL_PAGE) pg_prev[nx] = pv;
        pg_next[pg]  = NULL_PAGE;
        pg_prev[pg]  = NULL_PAGE;
        pg_state[pg] = bpa_pkg::PS_UNUSED;
        pg_order[pg] = '0;
        list_cnt[lv]--;
    endfunction

    // largest aligned blocks from first_page to the end
    function automatic void carve_pages();
        int idx, lv, n;
        wipe_records();
        idx = first_page;
        while (idx < NPG) begin
            lv = MAXO;
            while (lv > 0) begin
                n = 1 << lv;
                if ((idx & (n - 1)) == 0 && idx + n <= NPG) break;
                lv--;
            end
            link_head(idx, lv);
            shadow_free += 1 << lv;
            idx += 1 << lv;
        end
    endfunction

    function automatic bpa_pkg::t_status take_block(int lv, output int granted);
        int cur, pg;
        granted = 0;
        if (lv > MAXO) return bpa_pkg::ST_BAD_ORDER;
        cur = lv;
        while (cur <= MAXO && list_head[cur] >= NULL_PAGE) cur++;
        if (cur > MAXO) return bpa_pkg::ST_NO_BLOCK;
        pg = list_head[cur];
        unlink_free(pg, cur);
        // upper halves go back on the lists
        while (cur > lv) begin
            cur--;
            link_head(pg + (1 << cur), cur);
        end
        pg_state[pg] = bpa_pkg::PS_ALLOC;
        pg_order[pg] = 4'(lv);
        pg_next[pg]  = NULL_PAGE;
        pg_prev[pg]  = NULL_PAGE;
        shadow_free -= 1 << lv;
        granted = pg;
        return bpa_pkg::ST_OK;
    endfunction

    function automatic bpa_pkg::t_status release_block(int lv, int blk);
        int n, idx, bud, bn, cur;
        if (lv > MAXO) return bpa_pkg::ST_BAD_ORDER;
        n = 1 << lv;
        if (blk < first_page || blk + n > NPG) return bpa_pkg::ST_RANGE;
        if ((blk & (n - 1)) != 0) return bpa_pkg::ST_MISALIGN;
        if (pg_state[blk] != bpa_pkg::PS_ALLOC) return bpa_pkg::ST_NOT_ALLOC;
        if (pg_order[blk] != 4'(lv)) return bpa_pkg::ST_MISMATCH;
        pg_next[blk]  = NULL_PAGE;
        pg_prev[blk]  = NULL_PAGE;
        pg_state[blk] = bpa_pkg::PS_UNUSED;
        pg_order[blk] = '0;
        idx = blk;
        cur = lv;
        // merge upward while the buddy is a free block of the same order
        while (cur < MAXO) begin
            bn  = 1 << cur;
            bud = idx ^ bn;
            if (bud < first_page || bud + bn > NPG) break;
            if (pg_state[bud] != bpa_pkg::PS_FREE || pg_order[bud] != 4'(cur)) break;
            unlink_free(bud, cur);
            if (bud < idx) idx = bud;
            cur++;
        end
        link_head(idx, cur);
        shadow_free += n;
        return bpa_pkg::ST_OK;
    endfunction

    function automatic t_answer work_out(bpa_pkg::t_cmd c, int lv, int blk);
        t_answer a;
        int g;
        g = 0;
        a.status = bpa_pkg::ST_OK;
        case (c)
            bpa_pkg::CMD_INIT:  carve_pages();
            bpa_pkg::CMD_ALLOC: a.status = take_block(lv, g);
            bpa_pkg::CMD_FREE:  a.status = release_block(lv, blk);
            default:            ;
        endcase
        if (a.status != bpa_pkg::ST_OK) g = 0;
        a.granted = 15'(g);
        a.total   = 16'(shadow_free);
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            first_page = 0;
            wipe_records();
            answer_q.delete();
            mismatches = 0;
        end else begin
            // compare strobed result
            if (i_done) begin
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: st=%0d gi=%0d ft=%0d",
                                 $time, i_status, i_granted_index, i_free_total);
                end else begin
                    want = answer_q.pop_front();
                    if (i_status !== want.status || i_granted_index !== want.granted ||
                        i_free_total !== want.total) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp st=%0d gi=%0d ft=%0d got st=%0d gi=%0d ft=%0d",
                                     $time, want.status, want.granted, want.total,
                                     i_status, i_granted_index, i_free_total);
                    end
                end
            end
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == bpa_pkg::REG_FIRST_PAGE)
                first_page = int'(i_pwdata[14:0]);
            // accepted command
            if (i_start && !i_busy)
                answer_q.push_back(work_out(bpa_pkg::t_cmd'(i_cmd), int'(i_order),
                                            int'(i_block_index)));
        end
        o_errors <= mismatches + answer_q.size();
    end

endmodule

// ----- verif/buddy_page_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy page allocator testbench
// directed corner commands, then phases of random alloc and free traffic over
// several first_page settings and idle patterns, checked by a shadow allocator
// ----------------------------------------------------------------------------
module buddy_page_allocator_tb;

    localparam int         CYCLE_LIMIT    = 3000000;
    localparam int         NUM_PHASES     = 8;
    localparam int         PHASE_ITEMS    = 155;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = bpa_pkg::CMD_NONE;
    logic [3:0]  i_order = '0;
    logic [14:0] i_block_index = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [14:0] o_granted_index;
    logic [15:0] o_free_total;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          cycles = 0;

    // commands in flight and blocks currently held by the sender
    bpa_pkg::t_cmd inflight_q[$];
    logic [3:0]    inflight_ord_q[$];
    logic [14:0]   held_idx[$];
    logic [3:0]    held_ord[$];

    int          idle_pct;
    int          fp_plan[NUM_PHASES] = '{0, 32767, 1, -1, 16383, -1, 0, -1};
    int          idle_plan[NUM_PHASES] = '{0, 81, 17, 81, 0, 17, 81, 0};

    buddy_page_allocator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_order(i_order), .i_block_index(i_block_index),
        .o_done(o_done), .o_status(o_status), .o_granted_index(o_granted_index),
        .o_free_total(o_free_total), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    buddy_page_allocator_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_cmd(i_cmd), .i_order(i_order), .i_block_index(i_block_index),
        .i_done(o_done), .i_status(o_status), .i_granted_index(o_granted_index),
        .i_free_total(o_free_total), .i_psel(psel), .i_penable(penable),
        .i_pwrite(pwrite), .i_pready(pready), .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // learn granted blocks from results
    always @(posedge i_clk) begin
        if (o_done && inflight_q.size() > 0) begin
            if (inflight_q[0] == bpa_pkg::CMD_INIT) begin
                held_idx.delete();
                held_ord.delete();
            end else if (inflight_q[0] == bpa_pkg::CMD_ALLOC &&
                         o_status == bpa_pkg::ST_OK) begin
                held_idx.push_back(o_granted_index);
                held_ord.push_back(inflight_ord_q[0]);
            end
            void'(inflight_q.pop_front());
            void'(inflight_ord_q.pop_front());
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send(bpa_pkg::t_cmd c, logic [3:0] o, logic [14:0] b);
        logic taken;
        start         <= 1'b1;
        i_cmd         <= c;
        i_order       <= o;
        i_block_index <= b;
        do begin
            taken = !busy;
            @(posedge i_clk);
            if (taken) begin
                inflight_q.push_back(c);
                inflight_ord_q.push_back(o);
            end
            @(negedge i_clk);
        end while (!taken);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // hold off until every transaction has answered and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (inflight_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_first_page(logic [14:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= bpa_pkg::REG_FIRST_PAGE;
        pwdata  <= {17'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_command();
        int r, k;
        logic [3:0] o;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            o = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 4))
                                             : 4'($urandom_range(0, 15));
            send(bpa_pkg::CMD_ALLOC, o, 15'($urandom_range(0, 32767)));
        end else if (r < 88 && held_idx.size() > 0) begin
            k = $urandom_range(0, held_idx.size() - 1);
            o = held_ord[k];
            // now and then a wrong order, leaving the block held
            if ($urandom_range(0, 9) == 0)
                send(bpa_pkg::CMD_FREE, o + 4'd1, held_idx[k]);
            else begin
                send(bpa_pkg::CMD_FREE, o, held_idx[k]);
                held_idx.delete(k);
                held_ord.delete(k);
            end
        end else begin
            send(bpa_pkg::t_cmd'($urandom_range(1, 3)), 4'($urandom_range(0, 15)),
                 15'($urandom_range(0, 32767)));
        end
    endtask

    initial begin
        int fp;
        idle_pct = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // before any init
        send(bpa_pkg::CMD_ALLOC, 4'd0, 15'd0);
        send(bpa_pkg::CMD_FREE, 4'd0, 15'd0);
        send(bpa_pkg::CMD_FREE, 4'd15, 15'h7fff);
        send(bpa_pkg::CMD_NONE, 4'd15, 15'h7fff);
        drain();

        // first page off alignment
        write_first_page(15'd5);
        send(bpa_pkg::CMD_INIT, 4'd15, 15'h7fff);
        send(bpa_pkg::CMD_ALLOC, 4'd14, 15'd0);
        send(bpa_pkg::CMD_ALLOC, 4'd15, 15'd0);
        send(bpa_pkg::CMD_ALLOC, 4'd0, 15'd0);
        send(bpa_pkg::CMD_ALLOC, 4'd1, 15'd0);
        send(bpa_pkg::CMD_FREE, 4'd0, 15'd6);
        send(bpa_pkg::CMD_FREE, 4'd0, 15'd2);
        send(bpa_pkg::CMD_FREE, 4'd1, 15'h7fff);
        send(bpa_pkg::CMD_FREE, 4'd2, 15'd6);
        send(bpa_pkg::CMD_FREE, 4'd0, 15'd8);
        send(bpa_pkg::CMD_FREE, 4'd1, 15'd6);
        send(bpa_pkg::CMD_FREE, 4'd0, 15'd5);
        send(bpa_pkg::CMD_FREE, 4'd14, 15'd16384);
        send(bpa_pkg::CMD_ALLOC, 4'd14, 15'd0);
        send(bpa_pkg::CMD_ALLOC, 4'd14, 15'd0);
        drain();

        // random phases
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            fp = (fp_plan[ph] < 0) ? $urandom_range(0, 32767) : fp_plan[ph];
            if (ph == 3) fp = $urandom_range(0, 1023);
            idle_pct = idle_plan[ph];
            write_first_page(15'(fp));
            // one phase keeps the old lists under a new first page
            if (ph != 5) send(bpa_pkg::CMD_INIT, 4'($urandom_range(0, 15)),
                              15'($urandom_range(0, 32767)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                maybe_idle();
                random_command();
            end
            drain();
        end

        repeat (100) @(negedge i_clk);
        if (errors == 0 && inflight_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
